// ----- src/qss_pkg.sv -----
package qss_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_NAME  = 2'd1,
        KIND_ENTRY = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       has_name;
        logic       final_entry;
        logic       run_last;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

// ----- src/query_string_splitter.sv -----
// An accepted character is registered in the input register, decoded combinationally
// and written to the result queue once the queue has room for all of its results.
// Throughput: one character per cycle while the queue has room; an end transaction
// that cuts an escape short produces two results and fills the two-entry result queue.
// Reset: aresetn is synchronous and active low; it empties the input register and the
// result queue and clears the escape and name state.
module query_string_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data, [8] has_name, [9] final_entry, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // run_last
);

    logic             in_valid_reg;
    logic [7:0]       ch_reg;
    logic             eot_reg;
    logic             consume;
    logic [1:0]       res_count;
    logic [1:0]       push_count;
    logic [1:0]       space;
    qss_pkg::result_t res0, res1, head;

    assign consume    = in_valid_reg && (res_count <= space);
    assign s_tready   = !in_valid_reg || consume;
    assign push_count = consume ? res_count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            ch_reg  <= s_tdata;
            eot_reg <= s_tlast;
        end
    end

    qss_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ch          (ch_reg),
        .end_of_text (eot_reg),
        .advance     (consume),
        .res_count   (res_count),
        .res0        (res0),
        .res1        (res1)
    );

    qss_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .head       (head),
        .space      (space)
    );

    assign m_tdata = {6'd0, head.final_entry, head.has_name, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_last;

endmodule

// ----- src/qss_decode.sv -----
module qss_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           ch,
    input  logic                 end_of_text,
    input  logic                 advance,
    output logic [1:0]           res_count,
    output qss_pkg::result_t     res0,
    output qss_pkg::result_t     res1
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       name_seen_reg, name_seen_next;
    logic       is_end;

    assign is_end = end_of_text || (ch == qss_pkg::CH_NUL);

    always_comb begin
        phase_next     = phase_reg;
        nibble_next    = nibble_reg;
        name_seen_next = name_seen_reg;
        res_count      = 2'd0;
        res0           = '0;
        res1           = '0;
        if (is_end) begin
            if (phase_reg != PH_IDLE) begin
                res_count       = 2'd2;
                res0.kind       = qss_pkg::KIND_BYTE;
                res0.data       = {nibble_reg, 4'd0};
                res1.kind       = qss_pkg::KIND_ENTRY;
                res1.has_name   = name_seen_reg;
                res1.final_entry = 1'b1;
                res1.run_last   = 1'b1;
            end else begin
                res_count       = 2'd1;
                res0.kind       = qss_pkg::KIND_ENTRY;
                res0.has_name   = name_seen_reg;
                res0.final_entry = 1'b1;
                res0.run_last   = 1'b1;
            end
            phase_next     = PH_IDLE;
            nibble_next    = 4'd0;
            name_seen_next = 1'b0;
        end else if (phase_reg == PH_HIGH) begin
            nibble_next = qss_pkg::hex_value(ch);
            phase_next  = PH_LOW;
        end else if (phase_reg == PH_LOW) begin
            res_count     = 2'd1;
            res0.kind     = qss_pkg::KIND_BYTE;
            res0.data     = {nibble_reg, qss_pkg::hex_value(ch)};
            res0.run_last = 1'b1;
            phase_next    = PH_IDLE;
            nibble_next   = 4'd0;
        end else if (ch == qss_pkg::CH_EQ && !name_seen_reg) begin
            res_count      = 2'd1;
            res0.kind      = qss_pkg::KIND_NAME;
            res0.run_last  = 1'b1;
            name_seen_next = 1'b1;
        end else if (ch == qss_pkg::CH_AMP) begin
            res_count      = 2'd1;
            res0.kind      = qss_pkg::KIND_ENTRY;
            res0.has_name  = name_seen_reg;
            res0.run_last  = 1'b1;
            name_seen_next = 1'b0;
        end else if (ch == qss_pkg::CH_PLUS) begin
            res_count     = 2'd1;
            res0.kind     = qss_pkg::KIND_BYTE;
            res0.data     = qss_pkg::CH_SPACE;
            res0.run_last = 1'b1;
        end else if (ch == qss_pkg::CH_PCT) begin
            phase_next  = PH_HIGH;
            nibble_next = 4'd0;
        end else begin
            res_count     = 2'd1;
            res0.kind     = qss_pkg::KIND_BYTE;
            res0.data     = ch;
            res0.run_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            nibble_reg    <= 4'd0;
            name_seen_reg <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            nibble_reg    <= nibble_next;
            name_seen_reg <= name_seen_next;
        end
    end

    a_end_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_end |=> phase_reg == PH_IDLE && !name_seen_reg && nibble_reg == 4'd0)
        else $error("End transaction did not return the decoder to its start state.");

    a_pair_only_on_escape_end: assert property (@(posedge aclk) disable iff (!aresetn)
        res_count == 2'd2 |-> is_end && phase_reg != PH_IDLE
                              && res0.kind == qss_pkg::KIND_BYTE && !res0.run_last)
        else $error("Two results produced outside a truncated escape.");

    a_escape_low_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && phase_reg == PH_LOW && !is_end |-> res_count == 2'd1
                                               && res0.kind == qss_pkg::KIND_BYTE)
        else $error("Second hex digit did not yield a decoded byte.");

endmodule

// ----- src/qss_out_queue.sv -----
module qss_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           push_count,
    input  qss_pkg::result_t     push0,
    input  qss_pkg::result_t     push1,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output qss_pkg::result_t     head,
    output logic [1:0]           space
);

    qss_pkg::result_t entry_reg [qss_pkg::QUEUE_DEPTH];
    qss_pkg::result_t entry_next [qss_pkg::QUEUE_DEPTH];
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign m_tvalid = (count_reg != 2'd0);
    assign head     = entry_reg[0];
    assign space    = 2'(qss_pkg::QUEUE_DEPTH) - count_reg;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        entry_next = entry_reg;
        count_next = count_reg;
        if (pop) begin
            entry_next[0] = entry_reg[1];
            count_next    = count_reg - 2'd1;
        end
        if (push_count != 2'd0) begin
            entry_next[count_next[0]] = push0;
        end
        if (push_count == 2'd2) begin
            entry_next[1] = push1;
        end
        count_next = count_next + push_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        entry_reg <= entry_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(qss_pkg::QUEUE_DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_count != 2'd0 |-> ({1'b0, count_reg} + {1'b0, push_count}) <= 3'd2)
        else $error("Result queue written without room.");

    a_pop_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && count_reg == 2'd2 && push_count == 2'd0 |=> count_reg == 2'd1
                                                         && head == $past(entry_reg[1]))
        else $error("Queue head did not advance after a pop.");

endmodule

// ----- sim/query_string_splitter_test.sv -----
`timescale 1ns / 100ps

module query_string_splitter_test;

    localparam int ITEM_TARGET    = 1400;
    localparam int DRAIN_AT       = 700;
    localparam int LONG_HOLD_AT   = 250;
    localparam int LONG_HOLD_LEN  = 400;
    localparam int IDLE_LIMIT     = 3000;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } query_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    query_char_t      query_chars[$];
    qss_pkg::result_t decoded_due[$];

    esc_phase_t  esc_phase = ESC_NONE;
    logic [3:0]  high_digit = 4'h0;
    logic        name_given = 1'b0;

    int error_count = 0;
    int chars_accepted = 0;
    int results_seen = 0;
    int send_gap = 0;
    int send_quiet = 0;
    int recv_stall = 0;
    int recv_quiet = 0;
    int long_hold_left = 0;
    int idle_cycles = 0;
    bit drain_done = 1'b0;

    query_string_splitter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [3:0] digit_worth(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 4'(c - 8'h30);
        end
        if (c >= "a" && c <= "f") begin
            return 4'(c - 8'h57);
        end
        if (c >= "A" && c <= "F") begin
            return 4'(c - 8'h37);
        end
        return 4'h0;
    endfunction

    function automatic qss_pkg::result_t make_result(input qss_pkg::kind_t k,
                                                     input logic [7:0] d,
                                                     input logic h, input logic f);
        qss_pkg::result_t r;
        r.kind = k;
        r.data = d;
        r.has_name = h;
        r.final_entry = f;
        r.run_last = 1'b0;
        return r;
    endfunction

    task automatic decode_query_char(input logic [7:0] c, input logic eot);
        qss_pkg::result_t made[$];
        qss_pkg::result_t r;
        if (eot || c == qss_pkg::CH_NUL) begin
            if (esc_phase != ESC_NONE) begin
                made.push_back(make_result(qss_pkg::KIND_BYTE, {high_digit, 4'h0},
                                           1'b0, 1'b0));
            end
            made.push_back(make_result(qss_pkg::KIND_ENTRY, 8'h00, name_given, 1'b1));
            esc_phase = ESC_NONE;
            high_digit = 4'h0;
            name_given = 1'b0;
        end else if (esc_phase == ESC_HIGH) begin
            high_digit = digit_worth(c);
            esc_phase = ESC_LOW;
        end else if (esc_phase == ESC_LOW) begin
            made.push_back(make_result(qss_pkg::KIND_BYTE, {high_digit, digit_worth(c)},
                                       1'b0, 1'b0));
            esc_phase = ESC_NONE;
            high_digit = 4'h0;
        end else if (c == qss_pkg::CH_EQ && !name_given) begin
            made.push_back(make_result(qss_pkg::KIND_NAME, 8'h00, 1'b0, 1'b0));
            name_given = 1'b1;
        end else if (c == qss_pkg::CH_AMP) begin
            made.push_back(make_result(qss_pkg::KIND_ENTRY, 8'h00, name_given, 1'b0));
            name_given = 1'b0;
        end else if (c == qss_pkg::CH_PLUS) begin
            made.push_back(make_result(qss_pkg::KIND_BYTE, qss_pkg::CH_SPACE, 1'b0, 1'b0));
        end else if (c == qss_pkg::CH_PCT) begin
            esc_phase = ESC_HIGH;
            high_digit = 4'h0;
        end else begin
            made.push_back(make_result(qss_pkg::KIND_BYTE, c, 1'b0, 1'b0));
        end
        foreach (made[i]) begin
            r = made[i];
            r.run_last = (i == made.size() - 1);
            decoded_due.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        $display("%0t: mismatch in %s of result %0d: got %h, expected %h",
                 $realtime, what, results_seen, got, want);
    endtask

    function automatic int pick_gap(inout int quiet_left);
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet_left = $urandom_range(20, 60);
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    task automatic push_item(input logic [7:0] c, input logic eot);
        query_char_t it;
        it.ch = c;
        it.eot = eot;
        query_chars.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_item(s[i], 1'b0);
        end
    endtask

    task automatic push_end();
        if ($urandom_range(0, 3) == 0) begin
            push_item(qss_pkg::CH_NUL, 1'b0);
        end else begin
            push_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    function automatic logic [7:0] pick_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 19) == 0) begin
            return 8'($urandom_range(1, 255));
        end
        return digits[$urandom_range(0, 21)];
    endfunction

    task automatic push_field(input int len);
        int r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                push_item(8'("a" + $urandom_range(0, 25)), 1'b0);
            end else if (r < 45) begin
                push_item(8'("0" + $urandom_range(0, 9)), 1'b0);
            end else if (r < 60) begin
                push_item(qss_pkg::CH_PLUS, 1'b0);
            end else if (r < 75) begin
                push_item(qss_pkg::CH_PCT, 1'b0);
                push_item(pick_hex_char(), 1'b0);
                push_item(pick_hex_char(), 1'b0);
            end else if (r < 80) begin
                push_item(qss_pkg::CH_EQ, 1'b0);
            end else begin
                push_item(8'($urandom_range(1, 255)), 1'b0);
            end
        end
    endtask

    task automatic push_query_text();
        int entries;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            repeat ($urandom_range(1, 12)) push_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            entries = $urandom_range(1, 4);
            for (int e = 0; e < entries; e++) begin
                if (e > 0) begin
                    push_item(qss_pkg::CH_AMP, 1'b0);
                end
                if ($urandom_range(0, 3) != 0) begin
                    push_field($urandom_range(0, 5));
                    push_item(qss_pkg::CH_EQ, 1'b0);
                end
                push_field($urandom_range(0, 6));
            end
            if (r < 20) begin
                push_item(qss_pkg::CH_PCT, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    push_item(pick_hex_char(), 1'b0);
                end
            end
        end
        push_end();
    endtask

    always @(posedge aclk) begin : driver
        query_char_t it;
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                decode_query_char(s_tdata, s_tlast);
                chars_accepted++;
                next_valid = 1'b0;
                send_gap = pick_gap(send_quiet);
            end
            if (!next_valid) begin
                if (chars_accepted >= DRAIN_AT && !drain_done) begin
                    if (decoded_due.size() == 0) begin
                        drain_done = 1'b1;
                    end
                end else if (send_gap > 0) begin
                    send_gap--;
                end else if (query_chars.size() > 0) begin
                    it = query_chars.pop_front();
                    s_tdata <= it.ch;
                    s_tlast <= it.eot;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    always @(posedge aclk) begin : monitor
        qss_pkg::result_t want;
        int n;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (decoded_due.size() == 0) begin
                    report_mismatch("transaction with nothing expected",
                                    {m_tuser, m_tlast, m_tdata[12:0]}, 16'h0000);
                end else begin
                    want = decoded_due.pop_front();
                    if (m_tuser !== want.kind) begin
                        report_mismatch("kind", 16'(m_tuser), 16'(want.kind));
                    end
                    if (m_tdata[7:0] !== want.data) begin
                        report_mismatch("data", 16'(m_tdata[7:0]), 16'(want.data));
                    end
                    if (m_tdata[8] !== want.has_name) begin
                        report_mismatch("has_name", 16'(m_tdata[8]), 16'(want.has_name));
                    end
                    if (m_tdata[9] !== want.final_entry) begin
                        report_mismatch("final_entry", 16'(m_tdata[9]),
                                        16'(want.final_entry));
                    end
                    if (m_tlast !== want.run_last) begin
                        report_mismatch("run_last", 16'(m_tlast), 16'(want.run_last));
                    end
                    if (m_tdata[15:10] !== 6'd0) begin
                        report_mismatch("padding", 16'(m_tdata[15:10]), 16'h0000);
                    end
                end
                if (results_seen == LONG_HOLD_AT) begin
                    long_hold_left = LONG_HOLD_LEN;
                end
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                n = pick_gap(recv_quiet);
                if (n > 0) begin
                    recv_stall = n - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else if (query_chars.size() > 0 || s_tvalid || decoded_due.size() > 0) begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("query_string_splitter verification failed");
                $finish;
            end
        end
    end

    initial begin
        // Two entries, a repeated '=', escapes in both cases, a non-hex digit and
        // separators taken as digits, then an entry with no name.
        push_text("a=b=+%4a%Fz%g&&x");
        push_item(8'hFF, 1'b1);
        push_text("%A");
        push_item(qss_pkg::CH_NUL, 1'b0);
        push_item(qss_pkg::CH_PCT, 1'b0);
        push_item(8'h00, 1'b1);
        push_item(8'h5A, 1'b1);
        push_item(8'hFF, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'h01, 1'b1);
        while (query_chars.size() < ITEM_TARGET) begin
            push_query_text();
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (query_chars.size() > 0 || s_tvalid || decoded_due.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (decoded_due.size() > 0) begin
            report_mismatch("results never delivered", 16'(decoded_due.size()), 16'h0000);
        end
        if (error_count == 0) begin
            $display("query_string_splitter verification clean");
        end else begin
            $display("query_string_splitter verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/qss_pkg.sv
src/qss_decode.sv
src/qss_out_queue.sv
src/query_string_splitter.sv
sim/query_string_splitter_test.sv
